// ----- hdl/acrd_pkg.sv -----
// ----------------------------------------------------------------------------
// Audio clock rate detector package
// Widths, register indexes, record types and the rate table that the
// detector modules share.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acrd_pkg;

   localparam int COUNT_BITS   = 16;
   localparam int SCALE_W      = 17;
   localparam int TOL_W        = 9;
   localparam int RATE_W       = COUNT_BITS + SCALE_W;
   localparam int MILLI_W      = RATE_W + 10;
   localparam int LIM_W        = MILLI_W + 1;
   localparam int BASE_W       = 24;
   localparam int TF_W         = TOL_W + BASE_W;
   localparam int TYPE_W       = 4;
   localparam int TABLE_SLOTS  = 32;
   localparam int IDX_W        = $clog2(TABLE_SLOTS);
   localparam int RATE_ENTRIES = 13;
   localparam int DSD_FIRST    = 10;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 4;
   localparam int REG_SEL_W    = 2;

   localparam logic [REG_SEL_W-1:0] REG_TOLERANCE   = 2'd0;
   localparam logic [REG_SEL_W-1:0] REG_FRAME_SCALE = 2'd1;
   localparam logic [REG_SEL_W-1:0] REG_BIT_SCALE   = 2'd2;

   localparam logic [TOL_W-1:0]   TOLERANCE_RESET   = TOL_W'(40);
   localparam logic [SCALE_W-1:0] FRAME_SCALE_RESET = SCALE_W'(1000);
   localparam logic [SCALE_W-1:0] BIT_SCALE_RESET   = SCALE_W'(10000);

   localparam logic [TYPE_W-1:0]  TYPE_UNKNOWN = TYPE_W'(RATE_ENTRIES);
   localparam logic [LIM_W-1:0]   MILLI_ONE    = LIM_W'(1000);

   typedef struct packed {
      logic [TOL_W-1:0]   tolerance;
      logic [SCALE_W-1:0] frame_scale;
      logic [SCALE_W-1:0] bit_scale;
   } acrd_cfg_type;

   typedef struct packed {
      logic take;
      logic frame_pulse;
      logic bit_pulse;
      logic gate_end;
   } acrd_tick_type;

   typedef struct packed {
      logic               valid;
      logic [MILLI_W-1:0] frame_milli;
      logic [MILLI_W-1:0] bit_milli;
      logic [RATE_W-1:0]  frame_rate;
      logic [RATE_W-1:0]  bit_rate;
      logic               pair_hit;
      logic [IDX_W-1:0]   pair_idx;
      logic               dsd_hit;
      logic [IDX_W-1:0]   dsd_idx;
   } acrd_token_type;

   function automatic logic [BASE_W-1:0] rate_base(input logic [IDX_W-1:0] idx);
      logic [BASE_W-1:0] f;
      case (idx)
         5'd0: begin
            f = BASE_W'(32000);
         end
         5'd1: begin
            f = BASE_W'(44100);
         end
         5'd2: begin
            f = BASE_W'(48000);
         end
         5'd3: begin
            f = BASE_W'(88200);
         end
         5'd4: begin
            f = BASE_W'(96000);
         end
         5'd5: begin
            f = BASE_W'(176400);
         end
         5'd6: begin
            f = BASE_W'(192000);
         end
         5'd7: begin
            f = BASE_W'(352800);
         end
         5'd8: begin
            f = BASE_W'(384000);
         end
         5'd9: begin
            f = BASE_W'(705600);
         end
         5'd10: begin
            f = BASE_W'(2822400);
         end
         5'd11: begin
            f = BASE_W'(5644800);
         end
         5'd12: begin
            f = BASE_W'(11289600);
         end
         default: begin
            f = '0;
         end
      endcase
      return f;
   endfunction

   // Multiplies by 1000 as 1024 - 16 - 8.
   function automatic logic [MILLI_W-1:0] to_milli(input logic [RATE_W-1:0] x);
      logic [MILLI_W-1:0] m;
      m = MILLI_W'(x);
      return (m << 10) - (m << 4) - (m << 3);
   endfunction

endpackage

// ----- hdl/acrd_channels.sv -----
// ----------------------------------------------------------------------------
// Audio clock rate detector channels
// Valid/ready interfaces for the tick channel and the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface acrd_req_if;
   logic valid;
   logic ready;
   logic frame_pulse;
   logic bit_pulse;
   logic gate_end;

   modport source (output valid, output frame_pulse, output bit_pulse, output gate_end,
                   input ready);
   modport sink (input valid, input frame_pulse, input bit_pulse, input gate_end,
                 output ready);
endinterface

interface acrd_rsp_if;
   import acrd_pkg::*;

   logic               valid;
   logic               ready;
   logic [TYPE_W-1:0]  audio_type;
   logic [RATE_W-1:0]  frame_rate_hz;
   logic [RATE_W-1:0]  bit_rate_hz;

   modport source (output valid, output audio_type, output frame_rate_hz,
                   output bit_rate_hz, input ready);
   modport sink (input valid, input audio_type, input frame_rate_hz,
                 input bit_rate_hz, output ready);
endinterface

// ----- hdl/acrd_csr.sv -----
// ----------------------------------------------------------------------------
// Audio clock rate detector registers
// APB-style register file for the tolerance and the two scale factors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acrd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [acrd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [acrd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [acrd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output acrd_pkg::acrd_cfg_type             cfg
);
   import acrd_pkg::*;

   logic [TOL_W-1:0]     tolerance_ff;
   logic [TOL_W-1:0]     tolerance_in;
   logic [SCALE_W-1:0]   frame_scale_ff;
   logic [SCALE_W-1:0]   frame_scale_in;
   logic [SCALE_W-1:0]   bit_scale_ff;
   logic [SCALE_W-1:0]   bit_scale_in;
   logic [REG_SEL_W-1:0] reg_sel;
   logic                 write_en;

   assign reg_sel    = csr_paddr[REG_SEL_W+1:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      tolerance_in   = tolerance_ff;
      frame_scale_in = frame_scale_ff;
      bit_scale_in   = bit_scale_ff;
      if (write_en) begin
         case (reg_sel)
            REG_TOLERANCE: begin
               tolerance_in = csr_pwdata[TOL_W-1:0];
            end
            REG_FRAME_SCALE: begin
               frame_scale_in = csr_pwdata[SCALE_W-1:0];
            end
            REG_BIT_SCALE: begin
               bit_scale_in = csr_pwdata[SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_TOLERANCE: begin
            csr_prdata = CSR_DATA_W'(tolerance_ff);
         end
         REG_FRAME_SCALE: begin
            csr_prdata = CSR_DATA_W'(frame_scale_ff);
         end
         REG_BIT_SCALE: begin
            csr_prdata = CSR_DATA_W'(bit_scale_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff   <= TOLERANCE_RESET;
         frame_scale_ff <= FRAME_SCALE_RESET;
         bit_scale_ff   <= BIT_SCALE_RESET;
      end else begin
         tolerance_ff   <= tolerance_in;
         frame_scale_ff <= frame_scale_in;
         bit_scale_ff   <= bit_scale_in;
      end
   end

   assign cfg.tolerance   = tolerance_ff;
   assign cfg.frame_scale = frame_scale_ff;
   assign cfg.bit_scale   = bit_scale_ff;

endmodule

// ----- hdl/acrd_front.sv -----
// ----------------------------------------------------------------------------
// Audio clock rate detector front end
// Saturating pulse counters, gate-end capture, scaling to hertz and to
// thousandths of hertz for the classification chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acrd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  acrd_pkg::acrd_tick_type  tick,
   input  acrd_pkg::acrd_cfg_type   cfg,
   output acrd_pkg::acrd_token_type tok_out
);
   import acrd_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic [COUNT_BITS-1:0] frame_cnt_ff;
   logic [COUNT_BITS-1:0] frame_cnt_in;
   logic [COUNT_BITS-1:0] bit_cnt_ff;
   logic [COUNT_BITS-1:0] bit_cnt_in;
   logic [COUNT_BITS-1:0] frame_next;
   logic [COUNT_BITS-1:0] bit_next;
   logic                  snap_valid_ff;
   logic                  snap_valid_in;
   logic [COUNT_BITS-1:0] snap_frame_ff;
   logic [COUNT_BITS-1:0] snap_bit_ff;
   logic                  prod_valid_ff;
   logic [RATE_W-1:0]     prod_frame_ff;
   logic [RATE_W-1:0]     prod_bit_ff;
   acrd_token_type        tok_ff;
   acrd_token_type        tok_in;

   assign frame_next = (tick.frame_pulse && (frame_cnt_ff != COUNT_MAX)) ?
                       frame_cnt_ff + 1'b1 : frame_cnt_ff;
   assign bit_next   = (tick.bit_pulse && (bit_cnt_ff != COUNT_MAX)) ?
                       bit_cnt_ff + 1'b1 : bit_cnt_ff;

   always_comb begin
      frame_cnt_in  = frame_cnt_ff;
      bit_cnt_in    = bit_cnt_ff;
      snap_valid_in = 1'b0;
      if (tick.take) begin
         if (tick.gate_end) begin
            frame_cnt_in  = '0;
            bit_cnt_in    = '0;
            snap_valid_in = 1'b1;
         end else begin
            frame_cnt_in = frame_next;
            bit_cnt_in   = bit_next;
         end
      end
   end

   always_comb begin
      tok_in.valid       = prod_valid_ff;
      tok_in.frame_milli = to_milli(prod_frame_ff);
      tok_in.bit_milli   = to_milli(prod_bit_ff);
      tok_in.frame_rate  = prod_frame_ff;
      tok_in.bit_rate    = prod_bit_ff;
      tok_in.pair_hit    = 1'b0;
      tok_in.pair_idx    = '0;
      tok_in.dsd_hit     = 1'b0;
      tok_in.dsd_idx     = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_cnt_ff  <= '0;
         bit_cnt_ff    <= '0;
         snap_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         tok_ff.valid  <= 1'b0;
      end else begin
         frame_cnt_ff  <= frame_cnt_in;
         bit_cnt_ff    <= bit_cnt_in;
         snap_valid_ff <= snap_valid_in;
         prod_valid_ff <= snap_valid_ff;
         tok_ff        <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_valid_in) begin
         snap_frame_ff <= frame_next;
         snap_bit_ff   <= bit_next;
      end
      prod_frame_ff <= RATE_W'(snap_frame_ff) * RATE_W'(cfg.frame_scale);
      prod_bit_ff   <= RATE_W'(snap_bit_ff) * RATE_W'(cfg.bit_scale);
   end

   assign tok_out = tok_ff;

   a_frame_saturates: assert property (@(posedge clock) disable iff (reset)
      (tick.take && !tick.gate_end && (frame_cnt_ff == COUNT_MAX))
      |=> (frame_cnt_ff == COUNT_MAX))
      else $error("frame counter wrapped");

   a_gate_clears: assert property (@(posedge clock) disable iff (reset)
      (tick.take && tick.gate_end) |=> (frame_cnt_ff == '0) && (bit_cnt_ff == '0)
         && snap_valid_ff)
      else $error("gate end did not capture and clear the counters");

   a_product_follows: assert property (@(posedge clock) disable iff (reset)
      snap_valid_ff |=> prod_valid_ff ##1 tok_ff.valid)
      else $error("captured window lost before the chain");

endmodule

// ----- hdl/acrd_cell.sv -----
// ----------------------------------------------------------------------------
// Audio clock rate detector cell
// One rate table entry: checks the passing window against its frame rate,
// its bit rate and, for DSD entries, the bit rate alone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acrd_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [acrd_pkg::IDX_W-1:0]   cell_index,
   input  logic [acrd_pkg::TOL_W-1:0]   tolerance,
   input  acrd_pkg::acrd_token_type     tok_prev,
   output acrd_pkg::acrd_token_type     tok_next
);
   import acrd_pkg::*;

   logic [BASE_W-1:0]  base;
   logic [MILLI_W-1:0] center_frame;
   logic [MILLI_W-1:0] center_bit;
   logic [TF_W-1:0]    span_ff;
   logic [TF_W-1:0]    span_in;
   logic [LIM_W-1:0]   limit_frame;
   logic [LIM_W-1:0]   limit_bit;
   logic               hit_frame;
   logic               hit_bit_pair;
   logic               hit_bit_dsd;
   logic               dsd_cell;
   acrd_token_type     tok_ff;
   acrd_token_type     tok_in;

   // A rate x lies strictly inside c +- floor(c*t/1000) exactly when
   // 1000*|x - c| + 1000 <= c*t.
   function automatic logic near(input logic [MILLI_W-1:0] x,
                                 input logic [MILLI_W-1:0] c,
                                 input logic [LIM_W-1:0]   lim);
      logic [MILLI_W-1:0] delta;
      delta = (x >= c) ? (x - c) : (c - x);
      return (LIM_W'(delta) + MILLI_ONE) <= lim;
   endfunction

   assign base         = rate_base(cell_index);
   assign center_frame = to_milli(RATE_W'(base));
   assign center_bit   = to_milli(RATE_W'({base, 6'b0}));
   assign span_in      = TF_W'(tolerance) * TF_W'(base);
   assign limit_frame  = LIM_W'(span_ff);
   assign limit_bit    = LIM_W'({span_ff, 6'b0});
   assign dsd_cell     = (cell_index >= IDX_W'(DSD_FIRST));

   assign hit_frame    = near(tok_prev.frame_milli, center_frame, limit_frame);
   assign hit_bit_pair = near(tok_prev.bit_milli, center_bit, limit_bit);
   assign hit_bit_dsd  = near(tok_prev.bit_milli, center_frame, limit_frame);

   always_comb begin
      tok_in = tok_prev;
      if (!tok_prev.pair_hit && hit_frame && hit_bit_pair) begin
         tok_in.pair_hit = 1'b1;
         tok_in.pair_idx = cell_index;
      end
      if (dsd_cell && !tok_prev.dsd_hit && hit_bit_dsd) begin
         tok_in.dsd_hit = 1'b1;
         tok_in.dsd_idx = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      span_ff <= span_in;
   end

   assign tok_next = tok_ff;

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (tok_ff.valid && tok_ff.pair_hit) |-> (tok_ff.pair_idx <= cell_index))
      else $error("pair match index lies past this cell");

   a_dsd_range: assert property (@(posedge clock) disable iff (reset)
      (tok_ff.valid && tok_ff.dsd_hit) |-> (tok_ff.dsd_idx >= IDX_W'(DSD_FIRST)))
      else $error("second pass matched a non-DSD entry");

   a_step: assert property (@(posedge clock) disable iff (reset)
      tok_prev.valid |=> tok_ff.valid)
      else $error("window dropped inside the chain");

endmodule

// ----- hdl/audio_clock_rate_detector.sv -----
// ----------------------------------------------------------------------------
// Audio clock rate detector
// A window passes the capture, product and front token registers, 13-cell rate
// table chain and result register. Throughput: a tick without gate end is
// taken every cycle; a gate-end tick waits until the previous result has been
// taken, as one window runs through the chain at a time. Synchronous reset
// clears the counters, chain and result stage and restores register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module audio_clock_rate_detector (
   input  logic                               clock,
   input  logic                               reset,
   acrd_req_if.sink                           req_chan,
   acrd_rsp_if.source                         rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [acrd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [acrd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [acrd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import acrd_pkg::*;

   acrd_cfg_type        cfg;
   acrd_tick_type       tick;
   acrd_token_type      chain_tok [RATE_ENTRIES+1];
   acrd_token_type      last_tok;
   logic                gate_take;
   logic                rsp_take;
   logic                busy_ff;
   logic                busy_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [TYPE_W-1:0]   rsp_type_ff;
   logic [TYPE_W-1:0]   rsp_type_in;
   logic [RATE_W-1:0]   rsp_frame_ff;
   logic [RATE_W-1:0]   rsp_bit_ff;

   acrd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_chan.ready   = !busy_ff || !req_chan.gate_end;
   assign tick.take        = req_chan.valid && req_chan.ready;
   assign tick.frame_pulse = req_chan.frame_pulse;
   assign tick.bit_pulse   = req_chan.bit_pulse;
   assign tick.gate_end    = req_chan.gate_end;
   assign gate_take        = tick.take && req_chan.gate_end;

   acrd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .tick    (tick),
      .cfg     (cfg),
      .tok_out (chain_tok[0])
   );

   for (genvar i = 0; i < RATE_ENTRIES; i++) begin : g_cell
      acrd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .tolerance  (cfg.tolerance),
         .tok_prev   (chain_tok[i]),
         .tok_next   (chain_tok[i+1])
      );
   end

   assign last_tok = chain_tok[RATE_ENTRIES];
   assign rsp_take = rsp_valid_ff && rsp_chan.ready;

   always_comb begin
      if (last_tok.pair_hit) begin
         rsp_type_in = last_tok.pair_idx[TYPE_W-1:0];
      end else if (last_tok.dsd_hit) begin
         rsp_type_in = last_tok.dsd_idx[TYPE_W-1:0];
      end else begin
         rsp_type_in = TYPE_UNKNOWN;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (gate_take) begin
         busy_in = 1'b1;
      end else if (rsp_take) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (last_tok.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (last_tok.valid) begin
         rsp_type_ff  <= rsp_type_in;
         rsp_frame_ff <= last_tok.frame_rate;
         rsp_bit_ff   <= last_tok.bit_rate;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.audio_type    = rsp_type_ff;
   assign rsp_chan.frame_rate_hz = rsp_frame_ff;
   assign rsp_chan.bit_rate_hz   = rsp_bit_ff;

   a_result_owned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> busy_ff)
      else $error("result offered with no window in flight");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      last_tok.valid |-> !rsp_valid_ff)
      else $error("classified window would overwrite a pending result");

   a_gate_starts: assert property (@(posedge clock) disable iff (reset)
      gate_take |=> (busy_ff && !rsp_valid_ff))
      else $error("gate-end transfer taken while a result was pending");

endmodule
